>>> sv/vector3_normalize_top_defines.svh
// ---------------------------------------------------------------------------
// vector3_normalize_top_defines
// Assertion macros shared by the normalize block.
// ---------------------------------------------------------------------------
`ifndef VECTOR3_NORMALIZE_TOP_DEFINES_SVH
`define VECTOR3_NORMALIZE_TOP_DEFINES_SVH

// same-cycle implication
`define VN_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define VN_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/vn_pkg.sv
// ---------------------------------------------------------------------------
// vn_pkg
// Widths and stage record for the vector normalize pipeline.
// ---------------------------------------------------------------------------
package vn_pkg;

	localparam int CW   = 16;            // component width
	localparam int FB   = 15;            // fraction bits
	localparam int Q_W  = FB + 1;        // quotient / output width
	localparam int SQ_W = 2 * CW;        // one square
	localparam int S_W  = 2 * CW + 2;    // sum of three squares
	localparam int R_W  = SQ_W + 2 * FB; // remainder width
	localparam int P_W  = S_W + Q_W;     // running q*S
	localparam int T_W  = S_W + 2 * FB + 4;
	localparam int BI_W = $clog2(Q_W);

	typedef struct packed {
		logic                     zero;
		logic [2:0]               neg;
		logic [S_W-1:0]           s;
		logic [2:0][R_W-1:0]      d;
		logic [2:0][P_W-1:0]      p;
		logic [2:0][Q_W-1:0]      q;
	} vn_stage_t;

endpackage

>>> sv/vn_prep.sv
// ---------------------------------------------------------------------------
// vn_prep
// Magnitudes, squares and sum of squares over three stages.
// ---------------------------------------------------------------------------
module vn_prep import vn_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  vld_in,
	input  logic signed [CW-1:0]  comp_x,
	input  logic signed [CW-1:0]  comp_y,
	input  logic signed [CW-1:0]  comp_z,
	output logic                  vld_out,
	output vn_stage_t             st_out
);

	logic [2:0][CW-1:0]   mag_s1;
	logic [2:0]           neg_s1, neg_s2;
	logic [2:0][SQ_W-1:0] sq_s2;
	logic                 vld_s1, vld_s2, vld_s3;
	vn_stage_t            st_s3;
	logic [2:0][CW-1:0]   raw;
	logic [S_W-1:0]       sum;

	assign raw = {comp_z, comp_y, comp_x};
	assign sum = S_W'(sq_s2[0]) + S_W'(sq_s2[1]) + S_W'(sq_s2[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= raw[i][CW-1];
				mag_s1[i] <= raw[i][CW-1] ? (~raw[i] + CW'(1)) : raw[i];
				sq_s2[i]  <= SQ_W'(mag_s1[i]) * SQ_W'(mag_s1[i]);
				st_s3.d[i] <= {sq_s2[i], (2 * FB)'(0)};
				st_s3.p[i] <= '0;
				st_s3.q[i] <= '0;
			end
			neg_s2     <= neg_s1;
			st_s3.neg  <= neg_s2;
			st_s3.s    <= sum;
			st_s3.zero <= (sum == '0);
		end
	end

	assign vld_out = vld_s3;
	assign st_out  = st_s3;

endmodule

>>> sv/vn_step.sv
// ---------------------------------------------------------------------------
// vn_step
// One quotient bit for all three lanes: keep bit if t^2*S <= c^2*2^(2F), t = q + 2^b.
// ---------------------------------------------------------------------------
module vn_step import vn_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic [BI_W-1:0] bit_idx,
	input  logic            vld_in,
	input  vn_stage_t       st_in,
	output logic            vld_out,
	output vn_stage_t       st_out
);

	logic [BI_W:0]        sh1, sh2;
	logic [T_W-1:0]       s_ext;
	logic [2:0][T_W-1:0]  term, d_ext;
	logic [2:0]           take;
	vn_stage_t            nxt;

	assign sh1   = {1'b0, bit_idx} + (BI_W+1)'(1);
	assign sh2   = {bit_idx, 1'b0};
	assign s_ext = T_W'(st_in.s);

	// D = R - q^2*S ; P = q*S ; t = q + 2^b
	always_comb begin
		nxt = st_in;
		for (int i = 0; i < 3; i++) begin
			d_ext[i] = T_W'(st_in.d[i]);
			term[i]  = (T_W'(st_in.p[i]) << sh1) + (s_ext << sh2);
			take[i]  = (d_ext[i] >= term[i]);
			if (take[i]) begin
				nxt.d[i] = R_W'(d_ext[i] - term[i]);
				nxt.p[i] = st_in.p[i] + P_W'(s_ext << bit_idx);
				nxt.q[i] = st_in.q[i] | (Q_W'(1) << bit_idx);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_out <= nxt;
		end
	end

endmodule

>>> sv/vector3_normalize_top.sv
// Path from request accept to result valid: vn_prep stages, one vn_step stage per quotient bit, output register.
// Throughput: one request per cycle while out_stall does not hold the pipeline; one quotient bit per pipeline stage.
// out_stall freezes the whole pipeline while a result waits unaccepted.
// Reset clears all valid bits asynchronously; data registers are not reset.
// ---------------------------------------------------------------------------
// vector3_normalize_top
// Three-axis vector to Q1.15 unit vector, zero vector flagged.
// ---------------------------------------------------------------------------
`include "vector3_normalize_top_defines.svh"

module vector3_normalize_top import vn_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic signed [CW-1:0]  comp_x,
	input  logic signed [CW-1:0]  comp_y,
	input  logic signed [CW-1:0]  comp_z,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [Q_W-1:0] unit_x,
	output logic signed [Q_W-1:0] unit_y,
	output logic signed [Q_W-1:0] unit_z,
	output logic                  zero_length
);

	logic                 en;
	logic [Q_W:0]         vld_c;
	vn_stage_t            st_c [Q_W+1];
	logic [2:0][Q_W-1:0]  res;
	vn_stage_t            fin;

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	vn_prep u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (in_valid),
		.comp_x  (comp_x),
		.comp_y  (comp_y),
		.comp_z  (comp_z),
		.vld_out (vld_c[0]),
		.st_out  (st_c[0])
	);

	for (genvar g = 0; g < Q_W; g++) begin : g_step
		vn_step u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.bit_idx (BI_W'(FB - g)),
			.vld_in  (vld_c[g]),
			.st_in   (st_c[g]),
			.vld_out (vld_c[g+1]),
			.st_out  (st_c[g+1])
		);
	end

	assign fin = st_c[Q_W];

	// saturate +1.0, apply sign, force zero vector to zero
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			res[i] = fin.q[i];
			if (fin.q[i][FB]) begin
				res[i] = {1'b0, {FB{1'b1}}};
			end
			if (fin.neg[i]) begin
				res[i] = ~res[i] + Q_W'(1);
			end
			if (fin.zero) begin
				res[i] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_c[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			unit_x      <= res[0];
			unit_y      <= res[1];
			unit_z      <= res[2];
			zero_length <= fin.zero;
		end
	end

	`VN_ASSERT_IMP(a_zero_out, out_valid && zero_length, unit_x == '0 && unit_y == '0 && unit_z == '0, "zero vector gave nonzero unit")
	`VN_ASSERT_IMP(a_stall_src, in_stall, out_valid && out_stall, "input stalled without waiting result")
	`VN_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid && $stable(unit_x) && $stable(zero_length), "waiting result lost")

endmodule
